// ===== design/rvdec_pkg.sv =====
// Shared types and encodings for the RV64I instruction decoder.
`default_nettype none

package rvdec_pkg;

   localparam int INSTR_WIDTH = 32;
   localparam int OP_WIDTH    = 6;
   localparam int REG_WIDTH   = 5;
   localparam int SHAMT_WIDTH = 6;
   localparam int CSR_WIDTH   = 12;
   localparam int IMM_WIDTH   = 21;
   localparam int RSP_DATA_WIDTH = 64;

   // Dense operation numbers, in the order of the supported instruction list.
   typedef enum logic [OP_WIDTH-1:0] {
      OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_LWU, OP_LD, OP_SB, OP_SH, OP_SW,
      OP_SD, OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI,
      OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
      OP_FENCE, OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI, OP_ECALL,
      OP_EBREAK, OP_SRET,
      OP_MRET, OP_ADDIW, OP_SLLIW, OP_SRLIW, OP_SRAIW, OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW,
      OP_SRAW
   } rvdec_op_type;

   typedef struct packed {
      rvdec_op_type                op_code;
      logic                        unsupported;
      logic [REG_WIDTH-1:0]        dest_reg;
      logic [REG_WIDTH-1:0]        src1_reg;
      logic [REG_WIDTH-1:0]        src2_reg;
      logic [SHAMT_WIDTH-1:0]      shift_amount;
      logic [CSR_WIDTH-1:0]        csr_index;
      logic signed [IMM_WIDTH-1:0] immediate;
   } rvdec_result_type;

endpackage

`default_nettype wire

// ===== design/rvdec_decode.sv =====
// Combinational decode of one instruction word into an operation and its fields.
`default_nettype none

module rvdec_decode (
   input  wire logic [rvdec_pkg::INSTR_WIDTH-1:0] instr,
   output rvdec_pkg::rvdec_result_type           result
);
   import rvdec_pkg::*;

   localparam logic [6:0] OPC_LUI     = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC   = 7'b0010111;
   localparam logic [6:0] OPC_JAL     = 7'b1101111;
   localparam logic [6:0] OPC_JALR    = 7'b1100111;
   localparam logic [6:0] OPC_BRANCH  = 7'b1100011;
   localparam logic [6:0] OPC_LOAD    = 7'b0000011;
   localparam logic [6:0] OPC_STORE   = 7'b0100011;
   localparam logic [6:0] OPC_OPIMM   = 7'b0010011;
   localparam logic [6:0] OPC_OP      = 7'b0110011;
   localparam logic [6:0] OPC_MISCMEM = 7'b0001111;
   localparam logic [6:0] OPC_SYSTEM  = 7'b1110011;
   localparam logic [6:0] OPC_OPIMM32 = 7'b0011011;
   localparam logic [6:0] OPC_OP32    = 7'b0111011;

   // Arithmetic funct3 codes (OP, OP-IMM and their 32-bit forms).
   localparam logic [2:0] F3_ADD  = 3'b000;
   localparam logic [2:0] F3_SLL  = 3'b001;
   localparam logic [2:0] F3_SLT  = 3'b010;
   localparam logic [2:0] F3_SLTU = 3'b011;
   localparam logic [2:0] F3_XOR  = 3'b100;
   localparam logic [2:0] F3_SRL  = 3'b101;
   localparam logic [2:0] F3_OR   = 3'b110;
   localparam logic [2:0] F3_AND  = 3'b111;

   localparam logic [2:0] F3_BEQ  = 3'b000;
   localparam logic [2:0] F3_BNE  = 3'b001;
   localparam logic [2:0] F3_BLT  = 3'b100;
   localparam logic [2:0] F3_BGE  = 3'b101;
   localparam logic [2:0] F3_BLTU = 3'b110;
   localparam logic [2:0] F3_BGEU = 3'b111;

   localparam logic [2:0] F3_B    = 3'b000;
   localparam logic [2:0] F3_H    = 3'b001;
   localparam logic [2:0] F3_W    = 3'b010;
   localparam logic [2:0] F3_D    = 3'b011;
   localparam logic [2:0] F3_BU   = 3'b100;
   localparam logic [2:0] F3_HU   = 3'b101;
   localparam logic [2:0] F3_WU   = 3'b110;

   localparam logic [2:0] F3_PRIV   = 3'b000;
   localparam logic [2:0] F3_CSRRW  = 3'b001;
   localparam logic [2:0] F3_CSRRS  = 3'b010;
   localparam logic [2:0] F3_CSRRC  = 3'b011;
   localparam logic [2:0] F3_CSRRWI = 3'b101;
   localparam logic [2:0] F3_CSRRSI = 3'b110;
   localparam logic [2:0] F3_CSRRCI = 3'b111;

   localparam logic [2:0] F3_FENCE  = 3'b000;
   localparam logic [2:0] F3_FENCEI = 3'b001;

   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;
   localparam logic [5:0] F6_BASE = 6'b000000;
   localparam logic [5:0] F6_ALT  = 6'b010000;

   localparam logic [11:0] SYS_ECALL  = 12'h000;
   localparam logic [11:0] SYS_EBREAK = 12'h001;
   localparam logic [11:0] SYS_SRET   = 12'h102;
   localparam logic [11:0] SYS_MRET   = 12'h302;

   logic [6:0]           opc;
   logic [2:0]           f3;
   logic [5:0]           f6;
   logic [6:0]           f7;
   logic [11:0]          hi12;
   logic [IMM_WIDTH-1:0] imm_i;
   logic [IMM_WIDTH-1:0] imm_s;
   logic [IMM_WIDTH-1:0] imm_b;
   logic [IMM_WIDTH-1:0] imm_u;
   logic [IMM_WIDTH-1:0] imm_j;
   rvdec_op_type         op;
   logic                 bad;
   logic [IMM_WIDTH-1:0] imm;

   assign opc  = instr[6:0];
   assign f3   = instr[14:12];
   assign f6   = instr[31:26];
   assign f7   = instr[31:25];
   assign hi12 = instr[31:20];

   assign imm_i = {{9{instr[31]}}, instr[31:20]};
   assign imm_s = {{9{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b = {{8{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_u = {instr[31], instr[31:12]};
   assign imm_j = {instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

   always_comb begin
      op  = OP_LUI;
      bad = 1'b1;
      imm = '0;
      case (opc)
         OPC_LUI: begin
            op = OP_LUI; bad = 1'b0; imm = imm_u;
         end
         OPC_AUIPC: begin
            op = OP_AUIPC; bad = 1'b0; imm = imm_u;
         end
         OPC_JAL: begin
            op = OP_JAL; bad = 1'b0; imm = imm_j;
         end
         OPC_JALR: begin
            imm = imm_i;
            if (f3 == F3_ADD) begin
               op = OP_JALR; bad = 1'b0;
            end
         end
         OPC_BRANCH: begin
            imm = imm_b;
            bad = 1'b0;
            case (f3)
               F3_BEQ:  op = OP_BEQ;
               F3_BNE:  op = OP_BNE;
               F3_BLT:  op = OP_BLT;
               F3_BGE:  op = OP_BGE;
               F3_BLTU: op = OP_BLTU;
               F3_BGEU: op = OP_BGEU;
               default: bad = 1'b1;
            endcase
         end
         OPC_LOAD: begin
            imm = imm_i;
            bad = 1'b0;
            case (f3)
               F3_B:    op = OP_LB;
               F3_H:    op = OP_LH;
               F3_W:    op = OP_LW;
               F3_D:    op = OP_LD;
               F3_BU:   op = OP_LBU;
               F3_HU:   op = OP_LHU;
               F3_WU:   op = OP_LWU;
               default: bad = 1'b1;
            endcase
         end
         OPC_STORE: begin
            imm = imm_s;
            bad = 1'b0;
            case (f3)
               F3_B:    op = OP_SB;
               F3_H:    op = OP_SH;
               F3_W:    op = OP_SW;
               F3_D:    op = OP_SD;
               default: bad = 1'b1;
            endcase
         end
         OPC_OPIMM: begin
            imm = imm_i;
            bad = 1'b0;
            case (f3)
               F3_ADD:  op = OP_ADDI;
               F3_SLT:  op = OP_SLTI;
               F3_SLTU: op = OP_SLTIU;
               F3_XOR:  op = OP_XORI;
               F3_OR:   op = OP_ORI;
               F3_AND:  op = OP_ANDI;
               F3_SLL: begin
                  op  = OP_SLLI;
                  bad = (f6 != F6_BASE);
               end
               F3_SRL: begin
                  if (f6 == F6_BASE) op = OP_SRLI;
                  else if (f6 == F6_ALT) op = OP_SRAI;
                  else bad = 1'b1;
               end
               default: bad = 1'b1;
            endcase
         end
         OPC_OP: begin
            bad = 1'b0;
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD:  op = OP_ADD;
                  F3_SLL:  op = OP_SLL;
                  F3_SLT:  op = OP_SLT;
                  F3_SLTU: op = OP_SLTU;
                  F3_XOR:  op = OP_XOR;
                  F3_SRL:  op = OP_SRL;
                  F3_OR:   op = OP_OR;
                  F3_AND:  op = OP_AND;
                  default: bad = 1'b1;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               op = OP_SUB;
            end else if (f7 == F7_ALT && f3 == F3_SRL) begin
               op = OP_SRA;
            end else begin
               bad = 1'b1;
            end
         end
         OPC_MISCMEM: begin
            if (f3 == F3_FENCE || f3 == F3_FENCEI) begin
               op = OP_FENCE; bad = 1'b0;
            end
         end
         OPC_SYSTEM: begin
            bad = 1'b0;
            case (f3)
               F3_CSRRW:  op = OP_CSRRW;
               F3_CSRRS:  op = OP_CSRRS;
               F3_CSRRC:  op = OP_CSRRC;
               F3_CSRRWI: op = OP_CSRRWI;
               F3_CSRRSI: op = OP_CSRRSI;
               F3_CSRRCI: op = OP_CSRRCI;
               F3_PRIV: begin
                  // Trap and return operations are told apart by the upper twelve bits.
                  if (hi12 == SYS_ECALL) op = OP_ECALL;
                  else if (hi12 == SYS_EBREAK) op = OP_EBREAK;
                  else if (hi12 == SYS_SRET) op = OP_SRET;
                  else if (hi12 == SYS_MRET) op = OP_MRET;
                  else bad = 1'b1;
               end
               default: bad = 1'b1;
            endcase
         end
         OPC_OPIMM32: begin
            imm = imm_i;
            bad = 1'b0;
            if (f3 == F3_ADD) op = OP_ADDIW;
            else if (f3 == F3_SLL && f7 == F7_BASE) op = OP_SLLIW;
            else if (f3 == F3_SRL && f7 == F7_BASE) op = OP_SRLIW;
            else if (f3 == F3_SRL && f7 == F7_ALT) op = OP_SRAIW;
            else bad = 1'b1;
         end
         OPC_OP32: begin
            bad = 1'b0;
            if (f7 == F7_BASE && f3 == F3_ADD) op = OP_ADDW;
            else if (f7 == F7_ALT && f3 == F3_ADD) op = OP_SUBW;
            else if (f7 == F7_BASE && f3 == F3_SLL) op = OP_SLLW;
            else if (f7 == F7_BASE && f3 == F3_SRL) op = OP_SRLW;
            else if (f7 == F7_ALT && f3 == F3_SRL) op = OP_SRAW;
            else bad = 1'b1;
         end
         default: bad = 1'b1;
      endcase

      // An unsupported word reports operation zero and no immediate.
      if (bad) begin
         op  = OP_LUI;
         imm = '0;
      end
   end

   always_comb begin
      result.op_code      = op;
      result.unsupported  = bad;
      result.dest_reg     = instr[11:7];
      result.src1_reg     = instr[19:15];
      result.src2_reg     = instr[24:20];
      result.shift_amount = instr[25:20];
      result.csr_index    = hi12;
      result.immediate    = imm;
   end

endmodule

`default_nettype wire

// ===== design/rv64i_instruction_decoder.sv =====
// An accepted req beat goes through the input register, then the result register.
// Throughput: one instruction per cycle while rsp_tready is high; an input register
// feeds the decode logic, whose outcome lands in a result register that holds while
// rsp_tready is low. Reset: synchronous, active high; clears both stage valid flags.
// No beat is left in flight. Ready is combinational from rsp_tready through both stages.
`default_nettype none

module rv64i_instruction_decoder (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // instr_word[31:0]
   input  wire logic [rvdec_pkg::INSTR_WIDTH-1:0]    req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // op_code[5:0], dest_reg[10:6], src1_reg[15:11], src2_reg[20:16],
   // shift_amount[26:21], csr_index[38:27], immediate[59:39], zero[63:60]
   output logic [rvdec_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata,
   // unsupported[0]
   output logic                                      rsp_tuser
);
   import rvdec_pkg::*;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [INSTR_WIDTH-1:0] instr_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   rvdec_result_type       result_ff;
   rvdec_result_type       decoded;
   logic                   out_load;
   logic                   in_load;

   rvdec_decode u_decode (
      .instr  (instr_ff),
      .result (decoded)
   );

   // The result register takes a new beat when it is empty or being drained.
   assign out_load   = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_load;
   assign in_load    = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
      end
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         instr_ff <= req_tdata;
      end
      if (out_load && in_valid_ff) begin
         result_ff <= decoded;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = result_ff.unsupported;
   assign rsp_tdata  = {4'b0000,
                        result_ff.immediate,
                        result_ff.csr_index,
                        result_ff.shift_amount,
                        result_ff.src2_reg,
                        result_ff.src1_reg,
                        result_ff.dest_reg,
                        result_ff.op_code};

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking stream testbench for the RV64I instruction decoder.

module tb;
   import rvdec_pkg::*;

   // Major opcodes.
   localparam logic [6:0] OPC_LUI       = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC     = 7'b0010111;
   localparam logic [6:0] OPC_JAL       = 7'b1101111;
   localparam logic [6:0] OPC_JALR      = 7'b1100111;
   localparam logic [6:0] OPC_BRANCH    = 7'b1100011;
   localparam logic [6:0] OPC_LOAD      = 7'b0000011;
   localparam logic [6:0] OPC_STORE     = 7'b0100011;
   localparam logic [6:0] OPC_OP_IMM    = 7'b0010011;
   localparam logic [6:0] OPC_OP        = 7'b0110011;
   localparam logic [6:0] OPC_MISC_MEM  = 7'b0001111;
   localparam logic [6:0] OPC_SYSTEM    = 7'b1110011;
   localparam logic [6:0] OPC_OP_IMM_32 = 7'b0011011;
   localparam logic [6:0] OPC_OP_32     = 7'b0111011;
   localparam int         NUM_MAJOR     = 13;

   // funct3 values, grouped by instruction class.
   localparam logic [2:0] F3_ADD = 3'b000, F3_SLL = 3'b001, F3_SLT = 3'b010, F3_SLTU = 3'b011;
   localparam logic [2:0] F3_XOR = 3'b100, F3_SR = 3'b101, F3_OR = 3'b110, F3_AND = 3'b111;
   localparam logic [2:0] F3_BEQ = 3'b000, F3_BNE = 3'b001, F3_BLT = 3'b100, F3_BGE = 3'b101;
   localparam logic [2:0] F3_BLTU = 3'b110, F3_BGEU = 3'b111, F3_BRANCH_RSVD = 3'b010;
   localparam logic [2:0] F3_BYTE = 3'b000, F3_HALF = 3'b001, F3_WORD = 3'b010;
   localparam logic [2:0] F3_DOUBLE = 3'b011, F3_BYTE_U = 3'b100, F3_HALF_U = 3'b101;
   localparam logic [2:0] F3_WORD_U = 3'b110, F3_LOAD_RSVD = 3'b111, F3_STORE_RSVD = 3'b100;
   localparam logic [2:0] F3_FENCE = 3'b000, F3_FENCE_I = 3'b001;
   localparam logic [2:0] F3_PRIV = 3'b000, F3_CSRRW = 3'b001, F3_CSRRS = 3'b010;
   localparam logic [2:0] F3_CSRRC = 3'b011, F3_SYS_RSVD = 3'b100, F3_CSRRWI = 3'b101;
   localparam logic [2:0] F3_CSRRSI = 3'b110, F3_CSRRCI = 3'b111;

   localparam logic [6:0]  F7_BASE  = 7'b0000000;
   localparam logic [6:0]  F7_ALT   = 7'b0100000;
   localparam logic [6:0]  F7_MULDIV = 7'b0000001;
   localparam logic [5:0]  F6_BASE  = 6'b000000;
   localparam logic [5:0]  F6_SRA   = 6'b010000;
   localparam logic [11:0] SYS_ECALL  = 12'h000;
   localparam logic [11:0] SYS_EBREAK = 12'h001;
   localparam logic [11:0] SYS_SRET   = 12'h102;
   localparam logic [11:0] SYS_MRET   = 12'h302;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;

   rvdec_result_type decoded_q[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left  = 0;
   int          gap_max     = 0;
   bit          stall_enable = 1'b0;
   int          hold_cycles = 0;
   logic [15:0] stall_pattern = 16'hA5C3;

   rv64i_instruction_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Expected decode of one instruction word.
   function automatic rvdec_result_type decode_instr(input logic [31:0] w);
      rvdec_result_type r;
      logic        known;
      logic [2:0]  f3;
      logic [5:0]  f6;
      logic [6:0]  f7;
      logic [11:0] hi12;
      logic [20:0] imm_i, imm_s, imm_b, imm_u, imm_j;
      f3    = w[14:12];
      f6    = w[31:26];
      f7    = w[31:25];
      hi12  = w[31:20];
      imm_i = {{9{w[31]}}, w[31:20]};
      imm_s = {{9{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_u = {w[31], w[31:12]};
      imm_j = {w[31], w[19:12], w[20], w[30:21], 1'b0};
      known = 1'b1;
      r.op_code   = OP_LUI;
      r.immediate = '0;
      case (w[6:0])
         OPC_LUI: begin
            r.op_code = OP_LUI;
            r.immediate = imm_u;
         end
         OPC_AUIPC: begin
            r.op_code = OP_AUIPC;
            r.immediate = imm_u;
         end
         OPC_JAL: begin
            r.op_code = OP_JAL;
            r.immediate = imm_j;
         end
         OPC_JALR: begin
            r.op_code = OP_JALR;
            r.immediate = imm_i;
            known = (f3 == F3_ADD);
         end
         OPC_BRANCH: begin
            r.immediate = imm_b;
            case (f3)
               F3_BEQ:  r.op_code = OP_BEQ;
               F3_BNE:  r.op_code = OP_BNE;
               F3_BLT:  r.op_code = OP_BLT;
               F3_BGE:  r.op_code = OP_BGE;
               F3_BLTU: r.op_code = OP_BLTU;
               F3_BGEU: r.op_code = OP_BGEU;
               default: known = 1'b0;
            endcase
         end
         OPC_LOAD: begin
            r.immediate = imm_i;
            case (f3)
               F3_BYTE:   r.op_code = OP_LB;
               F3_HALF:   r.op_code = OP_LH;
               F3_WORD:   r.op_code = OP_LW;
               F3_DOUBLE: r.op_code = OP_LD;
               F3_BYTE_U: r.op_code = OP_LBU;
               F3_HALF_U: r.op_code = OP_LHU;
               F3_WORD_U: r.op_code = OP_LWU;
               default:   known = 1'b0;
            endcase
         end
         OPC_STORE: begin
            r.immediate = imm_s;
            case (f3)
               F3_BYTE:   r.op_code = OP_SB;
               F3_HALF:   r.op_code = OP_SH;
               F3_WORD:   r.op_code = OP_SW;
               F3_DOUBLE: r.op_code = OP_SD;
               default:   known = 1'b0;
            endcase
         end
         OPC_OP_IMM: begin
            r.immediate = imm_i;
            case (f3)
               F3_ADD:  r.op_code = OP_ADDI;
               F3_SLT:  r.op_code = OP_SLTI;
               F3_SLTU: r.op_code = OP_SLTIU;
               F3_XOR:  r.op_code = OP_XORI;
               F3_OR:   r.op_code = OP_ORI;
               F3_AND:  r.op_code = OP_ANDI;
               F3_SLL: begin
                  r.op_code = OP_SLLI;
                  known = (f6 == F6_BASE);
               end
               default: begin
                  if (f6 == F6_BASE) r.op_code = OP_SRLI;
                  else if (f6 == F6_SRA) r.op_code = OP_SRAI;
                  else known = 1'b0;
               end
            endcase
         end
         OPC_OP: begin
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD:  r.op_code = OP_ADD;
                  F3_SLL:  r.op_code = OP_SLL;
                  F3_SLT:  r.op_code = OP_SLT;
                  F3_SLTU: r.op_code = OP_SLTU;
                  F3_XOR:  r.op_code = OP_XOR;
                  F3_SR:   r.op_code = OP_SRL;
                  F3_OR:   r.op_code = OP_OR;
                  default: r.op_code = OP_AND;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_ADD) r.op_code = OP_SUB;
            else if (f7 == F7_ALT && f3 == F3_SR) r.op_code = OP_SRA;
            else known = 1'b0;
         end
         OPC_MISC_MEM: begin
            r.op_code = OP_FENCE;
            known = (f3 == F3_FENCE || f3 == F3_FENCE_I);
         end
         OPC_SYSTEM: begin
            case (f3)
               F3_PRIV: begin
                  case (hi12)
                     SYS_ECALL:  r.op_code = OP_ECALL;
                     SYS_EBREAK: r.op_code = OP_EBREAK;
                     SYS_SRET:   r.op_code = OP_SRET;
                     SYS_MRET:   r.op_code = OP_MRET;
                     default:    known = 1'b0;
                  endcase
               end
               F3_CSRRW:  r.op_code = OP_CSRRW;
               F3_CSRRS:  r.op_code = OP_CSRRS;
               F3_CSRRC:  r.op_code = OP_CSRRC;
               F3_CSRRWI: r.op_code = OP_CSRRWI;
               F3_CSRRSI: r.op_code = OP_CSRRSI;
               F3_CSRRCI: r.op_code = OP_CSRRCI;
               default:   known = 1'b0;
            endcase
         end
         OPC_OP_IMM_32: begin
            r.immediate = imm_i;
            if (f3 == F3_ADD) r.op_code = OP_ADDIW;
            else if (f3 == F3_SLL && f7 == F7_BASE) r.op_code = OP_SLLIW;
            else if (f3 == F3_SR && f7 == F7_BASE) r.op_code = OP_SRLIW;
            else if (f3 == F3_SR && f7 == F7_ALT) r.op_code = OP_SRAIW;
            else known = 1'b0;
         end
         OPC_OP_32: begin
            if (f7 == F7_BASE && f3 == F3_ADD) r.op_code = OP_ADDW;
            else if (f7 == F7_ALT && f3 == F3_ADD) r.op_code = OP_SUBW;
            else if (f7 == F7_BASE && f3 == F3_SLL) r.op_code = OP_SLLW;
            else if (f7 == F7_BASE && f3 == F3_SR) r.op_code = OP_SRLW;
            else if (f7 == F7_ALT && f3 == F3_SR) r.op_code = OP_SRAW;
            else known = 1'b0;
         end
         default: known = 1'b0;
      endcase
      // An unsupported word reports operation zero and no immediate.
      if (!known) begin
         r.op_code   = OP_LUI;
         r.immediate = '0;
      end
      r.unsupported  = !known;
      r.dest_reg     = w[11:7];
      r.src1_reg     = w[19:15];
      r.src2_reg     = w[24:20];
      r.shift_amount = w[25:20];
      r.csr_index    = w[31:20];
      return r;
   endfunction

   function automatic logic [31:0] r_word(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] opc);
      return {f7, rs2, rs1, f3, rd, opc};
   endfunction

   function automatic logic [6:0] major_opcode(input int idx);
      case (idx)
         0:  return OPC_LUI;
         1:  return OPC_AUIPC;
         2:  return OPC_JAL;
         3:  return OPC_JALR;
         4:  return OPC_BRANCH;
         5:  return OPC_LOAD;
         6:  return OPC_STORE;
         7:  return OPC_OP_IMM;
         8:  return OPC_OP;
         9:  return OPC_MISC_MEM;
         10: return OPC_SYSTEM;
         11: return OPC_OP_IMM_32;
         default: return OPC_OP_32;
      endcase
   endfunction

   // Styles 0 to 2 set the upper bits to a funct7/funct6 or system pattern; others leave them.
   function automatic logic [31:0] shape_upper(input logic [31:0] w, input int style);
      logic [31:0] s;
      s = w;
      case (style)
         0: s[31:25] = F7_BASE;
         1: s[31:25] = F7_ALT;
         2: begin
            case ($urandom_range(0, 3))
               0: s[31:20] = SYS_ECALL;
               1: s[31:20] = SYS_EBREAK;
               2: s[31:20] = SYS_SRET;
               default: s[31:20] = SYS_MRET;
            endcase
         end
         default: ;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] random_instr();
      logic [31:0] w;
      w = $urandom;
      // Most words carry a real major opcode; the rest are raw noise.
      if ($urandom_range(0, 9) < 8) begin
         w[6:0] = major_opcode($urandom_range(0, NUM_MAJOR - 1));
         w = shape_upper(w, $urandom_range(0, 3));
      end
      return w;
   endfunction

   task automatic send_instr(input logic [31:0] w);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decoded_q.push_back(decode_instr(w));
   endtask

   // Receiver: a rotating stall pattern, a free-running mode, and long hold-offs on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (!stall_enable) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            if ($urandom_range(0, 63) == 0) stall_pattern = 16'($urandom) | 16'h0001;
            rsp_tready <= stall_pattern[0];
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rvdec_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_q.size() == 0) begin
            $error("result beat %0h with no instruction outstanding", rsp_tdata);
            error_count++;
         end else begin
            want = decoded_q.pop_front();
            check_field("op_code", 32'(want.op_code), 32'(rsp_tdata[5:0]));
            check_field("unsupported", 32'(want.unsupported), 32'(rsp_tuser));
            check_field("dest_reg", 32'(want.dest_reg), 32'(rsp_tdata[10:6]));
            check_field("src1_reg", 32'(want.src1_reg), 32'(rsp_tdata[15:11]));
            check_field("src2_reg", 32'(want.src2_reg), 32'(rsp_tdata[20:16]));
            check_field("shift_amount", 32'(want.shift_amount), 32'(rsp_tdata[26:21]));
            check_field("csr_index", 32'(want.csr_index), 32'(rsp_tdata[38:27]));
            check_field("immediate", {11'b0, want.immediate}, {11'b0, rsp_tdata[59:39]});
            check_field("padding", 32'h0, 32'(rsp_tdata[63:60]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic test_directed_corners();
      gap_max = 2;
      stall_enable = 1'b1;
      send_instr(32'h0000_0000);
      send_instr(32'hFFFF_FFFF);
      send_instr({20'h80000, 5'd31, OPC_LUI});
      send_instr({20'h7FFFF, 5'd0, OPC_AUIPC});
      // Most negative and most positive jump offsets.
      send_instr({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL});
      send_instr({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, OPC_JAL});
      send_instr(r_word(7'h7F, 5'd31, 5'd0, F3_SLL, 5'd31, OPC_JALR));
      send_instr(r_word(7'h7F, 5'd31, 5'd0, F3_BGEU, 5'h1E, OPC_BRANCH));
      send_instr(r_word(7'h3F, 5'd0, 5'd31, F3_BRANCH_RSVD, 5'h01, OPC_BRANCH));
      send_instr(r_word(7'h40, 5'd0, 5'd1, F3_LOAD_RSVD, 5'd2, OPC_LOAD));
      send_instr(r_word(7'h3F, 5'd31, 5'd2, F3_DOUBLE, 5'h1F, OPC_STORE));
      send_instr(r_word(7'h00, 5'd1, 5'd2, F3_STORE_RSVD, 5'd3, OPC_STORE));
      // Trap returns and calls ignore rd and rs1.
      send_instr({SYS_ECALL, 5'd7, F3_PRIV, 5'd9, OPC_SYSTEM});
      send_instr({SYS_EBREAK, 5'd31, F3_PRIV, 5'd31, OPC_SYSTEM});
      send_instr({SYS_SRET, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM});
      send_instr({SYS_MRET, 5'd1, F3_PRIV, 5'd1, OPC_SYSTEM});
      send_instr({12'h7FF, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM});
      send_instr({12'hFFF, 5'd31, F3_SYS_RSVD, 5'd31, OPC_SYSTEM});
      send_instr({12'hFFF, 5'd31, F3_CSRRCI, 5'd31, OPC_SYSTEM});
      send_instr({12'hFFF, 5'd31, F3_FENCE, 5'd31, OPC_MISC_MEM});
      send_instr({12'h000, 5'd0, F3_FENCE_I, 5'd0, OPC_MISC_MEM});
      send_instr({12'h0FF, 5'd0, F3_WORD, 5'd0, OPC_MISC_MEM});
      // Shift immediates: a 6-bit amount is legal only for the 64-bit forms.
      send_instr(r_word({F6_BASE, 1'b1}, 5'd31, 5'd3, F3_SLL, 5'd4, OPC_OP_IMM));
      send_instr(r_word({F6_SRA, 1'b1}, 5'd31, 5'd3, F3_SR, 5'd4, OPC_OP_IMM));
      send_instr(r_word({6'b010001, 1'b0}, 5'd1, 5'd3, F3_SR, 5'd4, OPC_OP_IMM));
      send_instr(r_word({F6_BASE, 1'b1}, 5'd1, 5'd3, F3_SLL, 5'd4, OPC_OP_IMM_32));
      send_instr(r_word(F7_ALT, 5'd31, 5'd3, F3_SR, 5'd4, OPC_OP_IMM_32));
      send_instr(r_word(F7_MULDIV, 5'd5, 5'd6, F3_ADD, 5'd7, OPC_OP));
      send_instr(r_word(F7_ALT, 5'd5, 5'd6, F3_SLL, 5'd7, OPC_OP_32));
   endtask

   // Every major opcode against every funct3 and each upper-bit pattern.
   task automatic test_funct_sweep();
      logic [31:0] w;
      gap_max = 3;
      stall_enable = 1'b1;
      for (int m = 0; m < NUM_MAJOR; m++) begin
         for (int f = 0; f < 8; f++) begin
            for (int s = 0; s < 4; s++) begin
               w = $urandom;
               w[6:0] = major_opcode(m);
               w[14:12] = 3'(f);
               send_instr(shape_upper(w, s));
            end
         end
      end
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall the sender.
   task automatic test_receiver_hold();
      gap_max = 0;
      stall_enable = 1'b0;
      hold_cycles = 300;
      repeat (60) send_instr(random_instr());
   endtask

   task automatic test_random_stream();
      for (int seg = 0; seg < 7; seg++) begin
         case (seg % 4)
            0: begin
               gap_max = 0;
               stall_enable = 1'b0;
            end
            1: begin
               gap_max = 3;
               stall_enable = 1'b1;
            end
            2: begin
               gap_max = 12;
               stall_enable = 1'b1;
            end
            default: begin
               gap_max = 1;
               stall_enable = 1'b0;
            end
         endcase
         repeat (200) send_instr(random_instr());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_funct_sweep();
      test_receiver_hold();
      test_random_stream();
      req_tvalid <= 1'b0;
      stall_enable = 1'b1;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== rv64i_instruction_decoder.f =====
design/rvdec_pkg.sv
design/rvdec_decode.sv
design/rv64i_instruction_decoder.sv
tb/sv/tb.sv
